// ----- rtl/vrra_pkg.sv -----
// Package: request codes, state encoding and command/status types of the record ring allocator.
package vrra_pkg;

  localparam int unsigned HdrBytes = 4;

  typedef enum logic [2:0] {
    REQ_RESERVE  = 3'd0,
    REQ_COMMIT   = 3'd1,
    REQ_ALLOCATE = 3'd2,
    REQ_DELETE   = 3'd3,
    REQ_FIRST    = 3'd4,
    REQ_NEXT     = 3'd5,
    REQ_LENGTH   = 3'd6,
    REQ_NONE     = 3'd7
  } req_type_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RD_WAIT,
    ST_RD_USE,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_OUT
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic load_req;    // capture request fields
    logic do_reserve;  // evaluate reserve, write skip/header
    logic rd_req_hdr;  // read header at request address
    logic rd_cur_hdr;  // read header at walk cursor
    logic commit_chk;  // check/perform commit on read header (req address or reserved)
    logic del_mark;    // mark header removed, latch result
    logic len_res;     // latch length result
    logic walk_first;  // cursor = first header
    logic walk_next;   // cursor = header following read header
    logic walk_step;   // cursor = next of cursor (removed)
    logic walk_done;   // finish walk with cursor found/not
    logic set_fail;    // clear result, or take the reserve outcome
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic addr_ok;
    logic res_ok;      // reserve found a place
    logic cur_valid;   // walk cursor points at a header
    logic cur_removed; // header read at cursor is removed
    logic budget_left; // walk still within its visit budget
  } sts_t;

endpackage

// ----- rtl/vrra_ctrl.sv -----
// Controller: sequences each request through reserve, commit, and header walks.
module vrra_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_fire_i,
  input  logic [2:0]         req_type_i,
  input  logic               out_free_i,
  input  vrra_pkg::sts_t     sts_i,
  output vrra_pkg::cmd_t     cmd_o,
  output logic               busy_o,
  output logic               out_load_o
);
  import vrra_pkg::*;

  state_e state_q, state_d;
  req_type_e type_q, type_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      type_q  <= REQ_NONE;
    end else begin
      state_q <= state_d;
      type_q  <= type_d;
    end
  end

  always_comb begin
    state_d = state_q;
    type_d  = type_q;
    cmd_o   = '0;
    out_load_o = 1'b0;
    busy_o  = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          cmd_o.load_req = 1'b1;
          type_d  = req_type_e'(req_type_i);
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd_o.set_fail = 1'b1;
        state_d = ST_OUT;
        case (type_q)
          REQ_RESERVE: cmd_o.do_reserve = 1'b1;
          REQ_ALLOCATE: begin
            cmd_o.do_reserve = 1'b1;
            if (sts_i.res_ok) state_d = ST_RD_WAIT;
          end
          REQ_FIRST: begin
            cmd_o.walk_first = 1'b1;
            state_d = ST_WALK_RD;
          end
          REQ_COMMIT, REQ_DELETE, REQ_NEXT, REQ_LENGTH: begin
            if (sts_i.addr_ok) begin
              cmd_o.rd_req_hdr = 1'b1;
              state_d = ST_RD_WAIT;
            end
          end
          default: ;
        endcase
      end
      ST_RD_WAIT: state_d = ST_RD_USE;
      ST_RD_USE: begin
        state_d = ST_OUT;
        case (type_q)
          REQ_COMMIT, REQ_ALLOCATE: cmd_o.commit_chk = 1'b1;
          REQ_LENGTH: cmd_o.len_res = 1'b1;
          REQ_DELETE: begin
            cmd_o.del_mark   = 1'b1;
            cmd_o.walk_first = 1'b1;
            state_d = ST_WALK_RD;
          end
          REQ_NEXT: begin
            cmd_o.walk_next = 1'b1;
            state_d = ST_WALK_RD;
          end
          default: ;
        endcase
      end
      ST_WALK_RD: begin
        if (sts_i.cur_valid && sts_i.budget_left) begin
          cmd_o.rd_cur_hdr = 1'b1;
          state_d = ST_WALK_CHK;
        end else begin
          cmd_o.walk_done = 1'b1;
          state_d = ST_OUT;
        end
      end
      ST_WALK_CHK: begin
        if (!sts_i.cur_removed) begin
          cmd_o.walk_done = 1'b1;
          state_d = ST_OUT;
        end else begin
          cmd_o.walk_step = 1'b1;
          state_d = ST_WALK_RD;
        end
      end
      ST_OUT: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/vrra_dp.sv -----
// Datapath: pointers, header memory, reserve/commit arithmetic and walk cursor.
module vrra_dp #(
  parameter int unsigned RingDepth = 4096,
  parameter int unsigned PtrW      = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [12:0]       cfg_data_i,
  input  logic [11:0]       req_length_i,
  input  logic [11:0]       req_offset_i,
  input  vrra_pkg::cmd_t    cmd_i,
  output vrra_pkg::sts_t    sts_o,
  output logic              res_ok_o,
  output logic [11:0]       res_offset_o,
  output logic [11:0]       res_length_o,
  output logic [11:0]       used_o,
  output logic [11:0]       free_o
);
  import vrra_pkg::*;

  // Wide enough for a pointer plus header plus a 13-bit length field.
  localparam int unsigned SW = ((PtrW > 13) ? PtrW : 13) + 2;
  localparam logic [SW-1:0] Hdr = SW'(HdrBytes);
  localparam logic [SW-1:0] ResetSize = SW'((RingDepth < 4096) ? RingDepth : 4096);

  logic [SW-1:0] size_q;
  logic [PtrW-1:0] rp_q, wp_q;
  logic [11:0] len_q, off_q;
  logic [PtrW-1:0] hsel_q;       // header the current request works on
  logic [PtrW-1:0] cur_q;
  logic            cur_v_q;
  logic [SW-1:0]   budget_q;
  logic            is_del_q;
  logic            ok_q;
  logic [11:0]     ro_q, rl_q;

  logic [13:0] mem [RingDepth];
  logic [13:0] rdata_q;

  // Ring size from config, clamped.
  logic [SW-1:0] cfg_size;
  always_comb begin
    logic [SW:0] v;
    v = (SW+1)'(cfg_data_i);
    if (v < (SW+1)'(8)) v = (SW+1)'(8);
    if (v > (SW+1)'(RingDepth)) v = (SW+1)'(RingDepth);
    cfg_size = SW'(v);
  end

  // Address check on the captured offset.
  logic [SW-1:0] off_w, h_w;
  assign off_w = SW'(off_q);
  assign h_w   = off_w - Hdr;
  assign sts_o.addr_ok = (off_w >= Hdr) && (h_w < size_q);

  // Reserve placement.
  logic [SW-1:0] b_w, e_w, l_w, r_w;
  logic          res_ok;
  logic [SW-1:0] start_w;
  logic          skip_v;
  logic [SW-1:0] skip_w;
  assign b_w = SW'(rp_q);
  assign e_w = SW'(wp_q);
  assign l_w = SW'(len_q) + Hdr;
  assign r_w = size_q - e_w;
  always_comb begin
    res_ok  = 1'b0;
    start_w = e_w;
    skip_v  = 1'b0;
    skip_w  = r_w - Hdr - SW'(1);
    if (e_w >= b_w) begin
      if (r_w > l_w) res_ok = 1'b1;
      else if (b_w > l_w) begin
        res_ok  = 1'b1;
        start_w = '0;
        skip_v  = (r_w > Hdr);
      end
    end else if (b_w - e_w > l_w) res_ok = 1'b1;
  end
  assign sts_o.res_ok = res_ok;

  // Successor of a header given its length field.
  function automatic logic [SW:0] succ(input logic [PtrW-1:0] h, input logic [12:0] ln,
                                       input logic [SW-1:0] e, input logic [SW-1:0] s);
    logic [SW-1:0] st;
    logic          v;
    st = SW'(h) + Hdr + SW'(ln);
    v  = 1'b0;
    if (st != e) begin
      if (st > e) begin
        if (st < s && s - st > Hdr) v = 1'b1;
        else begin
          st = '0;
          v  = (e >= Hdr);
        end
      end else v = (e - st >= Hdr);
    end
    return {v, st};
  endfunction

  // First header.
  logic          first_v;
  logic [SW-1:0] first_h;
  always_comb begin
    first_v = 1'b0;
    first_h = b_w;
    if (e_w >= b_w) first_v = (e_w - b_w >= Hdr);
    else if (size_q - b_w > Hdr) first_v = 1'b1;
    else if (e_w >= Hdr) begin
      first_v = 1'b1;
      first_h = '0;
    end
  end

  logic [SW:0] nx_rd;
  assign nx_rd = succ(hsel_q, rdata_q[12:0], e_w, size_q);

  // Commit check on the header read back.
  logic          com_ok;
  logic [SW-1:0] com_end;
  assign com_end = SW'(hsel_q) + Hdr + SW'(len_q);
  assign com_ok  = (SW'(rdata_q[12:0]) >= SW'(len_q)) && (com_end < size_q);

  assign sts_o.cur_valid   = cur_v_q;
  assign sts_o.cur_removed = rdata_q[13];
  assign sts_o.budget_left = (budget_q != '0);

  // Memory port: one write, one registered read.
  logic            we;
  logic [PtrW-1:0] waddr, raddr;
  logic [13:0]     wdata;
  logic            we2;
  logic [PtrW-1:0] waddr2;
  logic [13:0]     wdata2;
  always_comb begin
    we = 1'b0; waddr = wp_q; wdata = '0;
    we2 = 1'b0; waddr2 = PtrW'(start_w); wdata2 = {1'b0, 1'b0, len_q};
    raddr = hsel_q;
    if (cmd_i.rd_req_hdr) raddr = PtrW'(h_w);
    if (cmd_i.do_reserve && res_ok) begin
      we2 = 1'b1;
      if (skip_v) begin
        we = 1'b1; waddr = wp_q; wdata = {1'b1, skip_w[12:0]};
      end
    end
    if (cmd_i.commit_chk && com_ok) begin
      we = 1'b1; waddr = hsel_q; wdata = {rdata_q[13], 1'b0, len_q};
    end
    if (cmd_i.del_mark) begin
      we = 1'b1; waddr = hsel_q; wdata = {1'b1, rdata_q[12:0]};
    end
    if (cmd_i.rd_cur_hdr) raddr = cur_q;
    if (cmd_i.do_reserve) raddr = PtrW'(start_w);
  end

  // Skip and header go out on consecutive cycles: skip now, header held in the pending register.
  logic            pend_q;
  logic [PtrW-1:0] pend_a_q;
  logic [13:0]     pend_d_q;
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    else if (pend_q) mem[pend_a_q] <= pend_d_q;
    rdata_q <= (pend_q && raddr == pend_a_q) ? pend_d_q : mem[raddr];
    pend_a_q <= waddr2;
    pend_d_q <= wdata2;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) pend_q <= 1'b0;
    else pend_q <= we2 && !(we && !skip_v);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= ResetSize;
      rp_q <= '0;
      wp_q <= '0;
    end else if (cfg_we_i) begin
      size_q <= cfg_size;
      rp_q <= '0;
      wp_q <= '0;
    end else begin
      if (cmd_i.commit_chk && com_ok) wp_q <= PtrW'(com_end);
      if (cmd_i.walk_done && is_del_q) begin
        rp_q <= (cur_v_q && !rdata_q[13] && budget_q != '0 && cur_v_q) ? cur_q : wp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      len_q <= req_length_i;
      off_q <= req_offset_i;
      is_del_q <= 1'b0;
    end
    // Clear the result, or take the reserve outcome when one is placed.
    if (cmd_i.set_fail) begin
      ok_q   <= cmd_i.do_reserve && res_ok;
      ro_q   <= (cmd_i.do_reserve && res_ok) ? 12'(start_w + Hdr) : '0;
      rl_q   <= (cmd_i.do_reserve && res_ok) ? len_q : '0;
      hsel_q <= cmd_i.do_reserve ? PtrW'(start_w) : PtrW'(h_w);
    end
    if (cmd_i.commit_chk) begin
      ok_q <= com_ok;
      ro_q <= com_ok ? 12'(SW'(hsel_q) + Hdr) : '0;
      rl_q <= com_ok ? len_q : '0;
    end
    if (cmd_i.len_res) begin
      ok_q <= 1'b1; ro_q <= off_q; rl_q <= rdata_q[11:0];
    end
    if (cmd_i.del_mark) begin
      ok_q <= 1'b1; ro_q <= off_q; rl_q <= rdata_q[11:0];
      is_del_q <= 1'b1;
    end
    if (cmd_i.walk_first) begin
      cur_q <= PtrW'(first_h); cur_v_q <= first_v; budget_q <= size_q;
    end
    if (cmd_i.walk_next) begin
      cur_q <= PtrW'(nx_rd[SW-1:0]); cur_v_q <= nx_rd[SW]; budget_q <= size_q;
    end
    if (cmd_i.rd_cur_hdr) hsel_q <= cur_q;
    if (cmd_i.walk_step) begin
      cur_q <= PtrW'(nx_rd[SW-1:0]); cur_v_q <= nx_rd[SW]; budget_q <= budget_q - SW'(1);
    end
    if (cmd_i.walk_done && !is_del_q) begin
      if (cur_v_q && budget_q != '0 && !rdata_q[13] && hsel_q == cur_q) begin
        ok_q <= 1'b1; ro_q <= 12'(SW'(cur_q) + Hdr); rl_q <= rdata_q[11:0];
      end
    end
  end

  // Walk-done flag on found is only taken from the check state (removed clear).
  assign res_ok_o     = ok_q;
  assign res_offset_o = ro_q;
  assign res_length_o = rl_q;

  logic [SW-1:0] u_w, f_w;
  always_comb begin
    u_w = (wp_q >= rp_q) ? SW'(wp_q) - SW'(rp_q) : SW'(wp_q) + size_q - SW'(rp_q);
    f_w = (rp_q > wp_q) ? SW'(rp_q) - SW'(wp_q) - SW'(1)
                        : size_q + SW'(rp_q) - SW'(wp_q) - SW'(1);
  end
  assign used_o = u_w[11:0];
  assign free_o = f_w[11:0];

endmodule

// ----- rtl/variable_record_ring_allocator.sv -----
// Top level: record ring allocator with stream request/result channels.
//
// Usage:
//   Requests arrive on the s_axis channel, one transfer per request; tdata
//   carries {req_offset, req_length, req_type}, req_type in the low bits. Each
//   request yields exactly one result transfer on m_axis carrying
//   {free_bytes, used_bytes, rec_length, rec_offset, ok}.
//   The ring size register is written through cfg_we_i/cfg_data_i; the user
//   must write it only while the block is idle, which the block does not
//   enforce. A write empties the ring (both pointers return to zero).
//   Reserve, unused codes and requests that fail their address or space
//   check go from decode straight to the result; commit, allocate and
//   length otherwise read one header first; first, next and delete walk
//   headers in the header RAM (one registered read port), up to the ring size.
//   One request is worked on at a time; s_axis_tready is high while the
//   controller is idle. The result is held in an output register, so the
//   next request is taken while a finished result waits for m_axis_tready.
//   After reset the ring size is RING_DEPTH (at most 4096), the ring is
//   empty and the header RAM holds no defined contents.
module variable_record_ring_allocator #(
  parameter int unsigned RING_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // req_type[2:0], req_length[14:3], req_offset[26:15]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // ok[0], rec_offset[12:1], rec_length[24:13],
                                      // used_bytes[36:25], free_bytes[48:37]
);
  import vrra_pkg::*;

  localparam int unsigned PtrW = $clog2(RING_DEPTH);

  cmd_t cmd;
  sts_t sts;
  logic busy, out_load, in_fire, out_free;
  logic ok_w;
  logic [11:0] ro_w, rl_w, used_w, free_w;
  logic        ov_q;
  logic [48:0] od_q;

  assign s_axis_tready = !busy;
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  // Result register frees when empty or being taken this cycle.
  assign out_free = !ov_q || m_axis_tready;

  vrra_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_fire_i (in_fire),
    .req_type_i(s_axis_tdata[2:0]),
    .out_free_i(out_free),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy_o    (busy),
    .out_load_o(out_load)
  );

  vrra_dp #(.RingDepth(RING_DEPTH), .PtrW(PtrW)) u_dp (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_data_i,
    .req_length_i(s_axis_tdata[14:3]),
    .req_offset_i(s_axis_tdata[26:15]),
    .cmd_i (cmd),
    .sts_o (sts),
    .res_ok_o(ok_w), .res_offset_o(ro_w), .res_length_o(rl_w),
    .used_o(used_w), .free_o(free_w)
  );

  // Output register: load a finished result, hold until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (out_load) ov_q <= 1'b1;
    else if (m_axis_tready) ov_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (out_load) od_q <= {free_w, used_w, rl_w, ro_w, ok_w};
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {7'd0, od_q};

`ifndef SYNTHESIS
  // A taken request leaves the controller busy.
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> busy) else $error("request taken but controller not busy");
  // A result is only loaded when the output register can take it.
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free) else $error("result overwritten");
  // A failed result carries zero offset and length.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[24:1] == '0))
    else $error("failed result carries data");
`endif

endmodule
